[design/bao_pkg.sv]
// Shared constants and types for the block address offset mapper.
// Used by bao_front, bao_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bao_pkg;

  // action codes of an input request
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_MAP   = 2'd2;

  // configuration register indexes
  localparam logic REG_SIZE_BITS  = 1'b0;
  localparam logic REG_BLOCK_BITS = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int SIZE_W     = 6;
  localparam int BLOCK_W    = 5;

  localparam logic [SIZE_W-1:0]  SIZE_BITS_RESET  = 6'd16;
  localparam logic [BLOCK_W-1:0] BLOCK_BITS_RESET = 5'd8;

  localparam int OFFSET_W = 32;
  localparam int DATA_W   = 8;

  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_ADDRESS_WIDTH = 32;

  // queue depths, powers of two
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // classification of one queued command
  typedef struct packed {
    logic is_map;
    logic is_write;
    logic hit;
  } cmd_ctl_t;

  localparam int CMD_CTL_W = $bits(cmd_ctl_t);

endpackage

`default_nettype wire

[design/bao_fifo.sv]
// Small register-based FIFO used for the command queue and the result queue.
// Depends on nothing; DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module bao_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic                          full,
  input  wire logic                     pop,
  output logic [WIDTH-1:0]              rdata,
  output logic                          empty,
  output logic [$clog2(DEPTH):0]        count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + (PW+1)'(1);
      else if (do_pop && !do_push) count <= count - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

[design/bao_front.sv]
// Front end: configuration registers, input acceptance and classification.
// Turns accesses into table indexes and maps into clamped index ranges; uses bao_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bao_front
  import bao_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 action,
  input  wire logic [ADDRESS_WIDTH-1:0]   address,
  input  wire logic [DATA_W-1:0]          write_data,
  input  wire logic [ADDRESS_WIDTH-1:0]   start_address,
  input  wire logic [ADDRESS_WIDTH-1:0]   end_address,
  input  wire logic signed [OFFSET_W-1:0] offset_value,
  input  wire logic                       clearing,
  input  wire logic                       cmd_full,
  output logic                            cmd_push,
  output cmd_ctl_t                        cmd_ctl,
  output logic [$clog2(TABLE_ENTRIES)-1:0] cmd_idx,
  output logic [$clog2(TABLE_ENTRIES)-1:0] cmd_last,
  output logic [ADDRESS_WIDTH-1:0]        cmd_address,
  output logic [DATA_W-1:0]               cmd_data,
  output logic [OFFSET_W-1:0]             cmd_offset
);

  localparam int AW        = ADDRESS_WIDTH;
  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int CMP_W     = (AW > IDX_W + 1) ? AW : IDX_W + 1;
  // smallest range exponent whose block count exceeds the table
  localparam int CAP_SHIFT = $clog2(TABLE_ENTRIES + 1);

  logic [SIZE_W-1:0]  size_bits;
  logic [BLOCK_W-1:0] block_bits;

  logic             accept;
  logic [AW-1:0]    win_mask;
  logic [CMP_W-1:0] acc_block;
  logic [CMP_W-1:0] map_first;
  logic [CMP_W-1:0] map_last;
  logic [CMP_W-1:0] limit_m1;
  logic [CMP_W-1:0] last_clamped;
  logic [SIZE_W-1:0] diff;
  logic             is_access;
  logic             map_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits  <= SIZE_BITS_RESET;
      block_bits <= BLOCK_BITS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SIZE_BITS:  size_bits  <= cfg_data;
        REG_BLOCK_BITS: block_bits <= cfg_data[BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  assign full   = cmd_full || clearing;
  assign accept = push && !full;

  always_comb begin
    // window mask saturates once the window covers every address bit
    if (7'(size_bits) >= 7'(AW)) win_mask = '1;
    else win_mask = ~({AW{1'b1}} << size_bits);

    acc_block = CMP_W'((address & win_mask) >> block_bits);
    map_first = CMP_W'(start_address >> block_bits);
    map_last  = CMP_W'(end_address >> block_bits);

    diff = size_bits - SIZE_W'(block_bits);
    if (SIZE_W'(block_bits) >= size_bits) limit_m1 = '0;
    else if (diff >= SIZE_W'(CAP_SHIFT)) limit_m1 = CMP_W'(TABLE_ENTRIES - 1);
    else limit_m1 = (CMP_W'(1) << diff) - CMP_W'(1);

    last_clamped = (map_last > limit_m1) ? limit_m1 : map_last;
    map_nonempty = (map_first <= last_clamped);
  end

  assign is_access = (action == ACT_READ) || (action == ACT_WRITE);

  always_comb begin
    cmd_push    = 1'b0;
    cmd_ctl     = '0;
    cmd_idx     = '0;
    cmd_last    = '0;
    cmd_address = '0;
    cmd_data    = '0;
    cmd_offset  = '0;
    if (is_access) begin
      cmd_push         = accept;
      cmd_ctl.is_write = (action == ACT_WRITE);
      cmd_ctl.hit      = (acc_block < CMP_W'(TABLE_ENTRIES));
      cmd_idx          = acc_block[IDX_W-1:0];
      cmd_address      = address;
      cmd_data         = (action == ACT_WRITE) ? write_data : '0;
    end else if (action == ACT_MAP) begin
      // an empty range is taken and dropped here
      cmd_push       = accept && map_nonempty;
      cmd_ctl.is_map = 1'b1;
      cmd_idx        = map_first[IDX_W-1:0];
      cmd_last       = last_clamped[IDX_W-1:0];
      cmd_offset     = $unsigned(offset_value);
    end
  end

endmodule

`default_nettype wire

[design/bao_back.sv]
// Back end: offset table memory, reset clearing pass, range fill sequencer
// and the access read pipeline that feeds the result queue; uses bao_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bao_back
  import bao_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int RES_FIFO_DEPTH = RES_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  output logic                                clearing,
  input  wire logic                           cmd_empty,
  output logic                                cmd_pop,
  input  wire cmd_ctl_t                       cmd_ctl,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] cmd_idx,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] cmd_last,
  input  wire logic [ADDRESS_WIDTH-1:0]       cmd_address,
  input  wire logic [DATA_W-1:0]              cmd_data,
  input  wire logic [OFFSET_W-1:0]            cmd_offset,
  input  wire logic [$clog2(RES_FIFO_DEPTH):0] res_count,
  output logic                                res_push,
  output logic [ADDRESS_WIDTH-1:0]            res_address,
  output logic                                res_is_write,
  output logic [DATA_W-1:0]                   res_data
);

  localparam int AW    = ADDRESS_WIDTH;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CW    = $clog2(RES_FIFO_DEPTH) + 1;
  localparam int SUM_W = (AW > OFFSET_W) ? AW : OFFSET_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [IDX_W-1:0]    clr_idx;
  logic [IDX_W-1:0]    fill_idx;
  logic [IDX_W-1:0]    fill_idx_next;
  logic [IDX_W-1:0]    fill_last;
  logic [OFFSET_W-1:0] fill_off;

  logic [OFFSET_W-1:0] table_mem [TABLE_ENTRIES];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [OFFSET_W-1:0] mem_wd;
  logic                mem_re;
  logic [OFFSET_W-1:0] rd_data;

  logic                s1_valid;
  logic [AW-1:0]       s1_address;
  logic                s1_is_write;
  logic                s1_hit;
  logic [DATA_W-1:0]   s1_data;
  logic                credit;
  logic                map_start;
  logic [SUM_W-1:0]    sum;
  logic [OFFSET_W-1:0] off;

  assign clearing = (state == ST_CLEAR);
  // room in the result queue, counting the read still in flight
  assign credit   = (res_count + CW'(s1_valid)) < CW'(RES_FIFO_DEPTH);

  always_comb begin
    state_next    = state;
    fill_idx_next = fill_idx;
    cmd_pop       = 1'b0;
    map_start     = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = fill_idx;
    mem_wd        = fill_off;
    mem_re        = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = '0;
        if (clr_idx == IDX_W'(TABLE_ENTRIES - 1)) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (!cmd_empty) begin
          if (cmd_ctl.is_map) begin
            // first block is written as the map leaves the queue
            cmd_pop       = 1'b1;
            map_start     = 1'b1;
            mem_we        = 1'b1;
            mem_wa        = cmd_idx;
            mem_wd        = cmd_offset;
            fill_idx_next = cmd_idx + IDX_W'(1);
            if (cmd_idx != cmd_last) state_next = ST_FILL;
          end else if (credit) begin
            cmd_pop = 1'b1;
            mem_re  = 1'b1;
          end
        end
      end
      ST_FILL: begin
        mem_we        = 1'b1;
        fill_idx_next = fill_idx + IDX_W'(1);
        if (fill_idx == fill_last) state_next = ST_RUN;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= mem_re;
      if (state == ST_CLEAR) clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    fill_idx <= fill_idx_next;
    if (map_start) begin
      fill_last <= cmd_last;
      fill_off  <= cmd_offset;
    end
    if (mem_re) begin
      s1_address  <= cmd_address;
      s1_is_write <= cmd_ctl.is_write;
      s1_hit      <= cmd_ctl.hit;
      s1_data     <= cmd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= table_mem[cmd_idx];
  end

  // offset is added unsigned; the wrap handles negative values if AW <= OFFSET_W
  assign off          = s1_hit ? rd_data : '0;
  assign sum          = SUM_W'(s1_address) + SUM_W'(off);
  assign res_push     = s1_valid;
  assign res_address  = sum[AW-1:0];
  assign res_is_write = s1_is_write;
  assign res_data     = s1_data;

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (res_count < CW'(RES_FIFO_DEPTH)))
    else $error("result queue overrun");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !cmd_pop)
    else $error("command taken during clearing pass");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (fill_idx <= fill_last))
    else $error("fill index ran past range end");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> s1_valid)
    else $error("issued read did not reach stage one");

endmodule

`default_nettype wire

[design/block_address_offset_mapper_unit.sv]
// Block address offset mapper, top level.
// Channels: input queue (push/full) carrying one request per item: action,
//   address, write_data, start_address, end_address, offset_value. Result
//   queue (empty/pop) carrying target_address, is_write, target_data.
//   Config: cfg_write/cfg_index/cfg_data, index 0 size_bits, 1 block_bits.
// Read and write requests give one result each; map requests give none.
// Path: a read or write request passes the command queue, the registered
//   table read and the result queue before it reaches the result ports.
// Throughput: one read or write per cycle while the result queue has room,
//   set by the single table read port. A map holds the table write port for
//   its blocks; queued accesses wait, up to four requests buffered meanwhile.
// Reset: synchronous, active high. Afterwards a clearing pass writes zero to
//   every table entry, with full held high; config writes are taken during
//   the pass.
// Stall: when pop stays low the four-entry result queue fills, then the
//   command queue, then full rises; no request is lost.
// Uses bao_pkg, bao_fifo, bao_front and bao_back.
`timescale 1ns / 1ps
`default_nettype none

module block_address_offset_mapper_unit
  import bao_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 action,
  input  wire logic [ADDRESS_WIDTH-1:0]   address,
  input  wire logic [DATA_W-1:0]          write_data,
  input  wire logic [ADDRESS_WIDTH-1:0]   start_address,
  input  wire logic [ADDRESS_WIDTH-1:0]   end_address,
  input  wire logic signed [OFFSET_W-1:0] offset_value,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [ADDRESS_WIDTH-1:0]        target_address,
  output logic                            is_write,
  output logic [DATA_W-1:0]               target_data
);

  localparam int AW    = ADDRESS_WIDTH;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CMD_W = CMD_CTL_W + 2 * IDX_W + AW + DATA_W + OFFSET_W;
  localparam int RES_W = AW + 1 + DATA_W;

  logic                 clearing;
  logic                 cmd_full;
  logic                 cmd_push;
  logic                 cmd_empty;
  logic                 cmd_pop;
  cmd_ctl_t             f_ctl;
  logic [IDX_W-1:0]     f_idx;
  logic [IDX_W-1:0]     f_last;
  logic [AW-1:0]        f_address;
  logic [DATA_W-1:0]    f_data;
  logic [OFFSET_W-1:0]  f_offset;
  cmd_ctl_t             b_ctl;
  logic [IDX_W-1:0]     b_idx;
  logic [IDX_W-1:0]     b_last;
  logic [AW-1:0]        b_address;
  logic [DATA_W-1:0]    b_data;
  logic [OFFSET_W-1:0]  b_offset;
  logic [CMD_W-1:0]     cmd_wdata;
  logic [CMD_W-1:0]     cmd_rdata;

  logic                 res_push;
  logic [AW-1:0]        res_address;
  logic                 res_is_write;
  logic [DATA_W-1:0]    res_data;
  logic [RES_W-1:0]     res_rdata;
  logic [$clog2(RES_DEPTH):0] res_count;

  bao_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .action        (action),
    .address       (address),
    .write_data    (write_data),
    .start_address (start_address),
    .end_address   (end_address),
    .offset_value  (offset_value),
    .clearing      (clearing),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_ctl       (f_ctl),
    .cmd_idx       (f_idx),
    .cmd_last      (f_last),
    .cmd_address   (f_address),
    .cmd_data      (f_data),
    .cmd_offset    (f_offset)
  );

  assign cmd_wdata = {f_ctl, f_idx, f_last, f_address, f_data, f_offset};
  assign {b_ctl, b_idx, b_last, b_address, b_data, b_offset} = cmd_rdata;

  bao_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty),
    .count ()
  );

  bao_back #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .ADDRESS_WIDTH  (ADDRESS_WIDTH),
    .RES_FIFO_DEPTH (RES_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .cmd_ctl      (b_ctl),
    .cmd_idx      (b_idx),
    .cmd_last     (b_last),
    .cmd_address  (b_address),
    .cmd_data     (b_data),
    .cmd_offset   (b_offset),
    .res_count    (res_count),
    .res_push     (res_push),
    .res_address  (res_address),
    .res_is_write (res_is_write),
    .res_data     (res_data)
  );

  bao_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata ({res_address, res_is_write, res_data}),
    .full  (),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty),
    .count (res_count)
  );

  assign {target_address, is_write, target_data} = res_rdata;

endmodule

`default_nettype wire
